[hw/rtl/jetp_pkg.sv]
// shared types and constants for the julia escape-time pixel block
package jetp_pkg;

	localparam int FRAC_BITS = 28;
	localparam int MAX_DIM   = 8192;
	localparam int PIX_W     = 13;
	localparam int ITER_W    = 10;
	localparam int BYTE_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;
	localparam int STEP_W    = 3;

	localparam logic [CFG_IDX_W-1:0] REG_C_REAL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_C_IMAG   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_START  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Y_START  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DARK     = 3'd7;

	localparam logic signed [47:0] S32_MAX = 48'sh0000_7FFF_FFFF;
	localparam logic signed [47:0] S32_MIN = 48'shFFFF_8000_0000;

	typedef struct packed {
		logic signed [31:0] c_real;
		logic signed [31:0] c_imag;
		logic signed [31:0] x_start;
		logic signed [31:0] x_step;
		logic signed [31:0] y_start;
		logic signed [31:0] y_step;
		logic [ITER_W-1:0]  max_iter;
		logic [BYTE_W-1:0]  dark;
	} cfg_t;

	typedef struct packed {
		logic              load;
		logic              coord;
		logic              iter;
		logic              div;
		logic              bright;
		logic              sqrt;
		logic              out_load;
		logic [STEP_W-1:0] step;
	} dp_cmd_t;

	typedef struct packed {
		logic finish;
	} dp_status_t;

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if (v > S32_MAX) begin
			return 32'sh7FFF_FFFF;
		end else if (v < S32_MIN) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic [PIX_W-1:0] clamp_idx(input logic [PIX_W-1:0] i);
		if (32'(i) >= 32'(MAX_DIM)) begin
			return PIX_W'(MAX_DIM - 1);
		end
		return i;
	endfunction

endpackage

[hw/rtl/jetp_cfg.sv]
// configuration register file
module jetp_cfg import jetp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.c_real   <= 32'sd102046330;
			cfg_q.c_imag   <= -32'sd41494218;
			cfg_q.x_start  <= -32'sd322122547;
			cfg_q.x_step   <= 32'sd128849;
			cfg_q.y_start  <= -32'sd322122547;
			cfg_q.y_step   <= 32'sd128849;
			cfg_q.max_iter <= ITER_W'(200);
			cfg_q.dark     <= BYTE_W'(20);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_C_REAL:   cfg_q.c_real   <= cfg_wr_data;
				REG_C_IMAG:   cfg_q.c_imag   <= cfg_wr_data;
				REG_X_START:  cfg_q.x_start  <= cfg_wr_data;
				REG_X_STEP:   cfg_q.x_step   <= cfg_wr_data;
				REG_Y_START:  cfg_q.y_start  <= cfg_wr_data;
				REG_Y_STEP:   cfg_q.y_step   <= cfg_wr_data;
				REG_MAX_ITER: cfg_q.max_iter <= cfg_wr_data[ITER_W-1:0];
				REG_DARK:     cfg_q.dark     <= cfg_wr_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/jetp_dp.sv]
// datapath: coordinate mapping, iteration, brightness divide, square root, output register
module jetp_dp import jetp_pkg::*; (
	input  logic              clk,
	input  cfg_t              cfg,
	input  dp_cmd_t           cmd,
	input  logic [PIX_W-1:0]  pixel_x,
	input  logic [PIX_W-1:0]  pixel_y,
	output dp_status_t        st,
	output logic [BYTE_W-1:0] red,
	output logic [BYTE_W-1:0] green,
	output logic [BYTE_W-1:0] blue,
	output logic [ITER_W-1:0] escape_count
);

	localparam int SQ_W  = 64 - FRAC_BITS;
	localparam int NUM_W = ITER_W + BYTE_W;
	localparam logic [SQ_W:0] ESC_LIMIT = (SQ_W+1)'(64'd4 << FRAC_BITS);

	function automatic logic [BYTE_W-1:0] div255(input logic [15:0] x);
		logic [15:0] est;
		logic [15:0] rem;
		est = (x + (x >> 8)) >> 8;
		rem = x - ((est << 8) - est);
		if (rem >= 16'd255) begin
			est = est + 16'd1;
		end
		return est[BYTE_W-1:0];
	endfunction

	logic signed [45:0]  prod_x_q, prod_y_q;
	logic signed [31:0]  a_q, b_q;
	logic [ITER_W-1:0]   u_q, n_q;
	logic [NUM_W-1:0]    num_q;
	logic [BYTE_W-1:0]   quo_q, bright_q, root_q;
	logic [15:0]         bsq_q;
	logic [BYTE_W-1:0]   red_q, green_q, blue_q;
	logic [ITER_W-1:0]   cnt_out_q;

	logic [31:0]         mag_a, mag_b;
	logic [63:0]         sqa_full, sqb_full;
	logic [SQ_W-1:0]     sa, sb;
	logic signed [63:0]  ab;
	logic signed [47:0]  na_wide, nb_wide, ca_wide, cb_wide;
	logic [SQ_W:0]       mag_sum;
	logic                esc, finish;
	logic [ITER_W-1:0]   n_next;
	logic [NUM_W-1:0]    div_d;
	logic [BYTE_W-1:0]   root_t;
	logic [15:0]         root_tt, bright_v;

	always_comb begin
		mag_a    = a_q[31] ? 32'(-a_q) : a_q;
		mag_b    = b_q[31] ? 32'(-b_q) : b_q;
		sqa_full = 64'(mag_a) * 64'(mag_a);
		sqb_full = 64'(mag_b) * 64'(mag_b);
		sa       = sqa_full[63:FRAC_BITS];
		sb       = sqb_full[63:FRAC_BITS];
		ab       = a_q * b_q;
		na_wide  = $signed(48'(sa)) - $signed(48'(sb)) + 48'(cfg.c_real);
		nb_wide  = 48'($signed(ab[63:FRAC_BITS-1])) + 48'(cfg.c_imag);
		mag_sum  = (SQ_W+1)'(sa) + (SQ_W+1)'(sb);
		esc      = (u_q != '0) && (mag_sum > ESC_LIMIT);
		finish   = esc || (u_q == cfg.max_iter);
		n_next   = esc ? u_q - ITER_W'(1) : u_q;
		ca_wide  = 48'(prod_x_q) + 48'(cfg.x_start);
		cb_wide  = 48'(prod_y_q) + 48'(cfg.y_start);
		div_d    = NUM_W'(cfg.max_iter) << cmd.step;
		root_t   = root_q | (BYTE_W'(1) << cmd.step);
		root_tt  = 16'(root_t) * 16'(root_t);
		bright_v = {bright_q, 8'b0} - 16'(bright_q);
	end

	assign st.finish = finish;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			prod_x_q <= $signed({1'b0, clamp_idx(pixel_x)}) * cfg.x_step;
			prod_y_q <= $signed({1'b0, clamp_idx(pixel_y)}) * cfg.y_step;
		end
		if (cmd.coord) begin
			a_q <= sat32(ca_wide);
			b_q <= sat32(cb_wide);
			u_q <= '0;
		end
		if (cmd.iter) begin
			if (finish) begin
				n_q   <= n_next;
				num_q <= {n_next, 8'b0} - NUM_W'(n_next);
				quo_q <= '0;
			end else begin
				a_q <= sat32(na_wide);
				b_q <= sat32(nb_wide);
				u_q <= u_q + ITER_W'(1);
			end
		end
		if (cmd.div) begin
			if (num_q >= div_d) begin
				num_q              <= num_q - div_d;
				quo_q[cmd.step]    <= 1'b1;
			end
		end
		if (cmd.bright) begin
			bright_q <= ((n_q == cfg.max_iter) || (quo_q < cfg.dark)) ? '0 : quo_q;
			root_q   <= '0;
		end
		if (cmd.sqrt) begin
			if (root_tt <= bright_v) begin
				root_q <= root_t;
			end
			bsq_q <= 16'(bright_q) * 16'(bright_q);
		end
		if (cmd.out_load) begin
			red_q     <= root_q;
			green_q   <= div255(bsq_q);
			blue_q    <= bright_q;
			cnt_out_q <= n_q;
		end
	end

	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign escape_count = cnt_out_q;

endmodule

[hw/rtl/jetp_ctrl.sv]
// controller state machine and output handshake
module jetp_ctrl import jetp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_COORD  = 7'b0000010,
		S_ITER   = 7'b0000100,
		S_DIV    = 7'b0001000,
		S_BRIGHT = 7'b0010000,
		S_SQRT   = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	logic              out_valid_q;
	logic              out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		cmd.step = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_COORD;
				end
			end
			S_COORD: begin
				cmd.coord = 1'b1;
				state_d   = S_ITER;
			end
			S_ITER: begin
				cmd.iter = 1'b1;
				if (st.finish) begin
					cnt_d   = '1;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div = 1'b1;
				cnt_d   = cnt_q - STEP_W'(1);
				if (cnt_q == '0) begin
					state_d = S_BRIGHT;
				end
			end
			S_BRIGHT: begin
				cmd.bright = 1'b1;
				cnt_d      = '1;
				state_d    = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt = 1'b1;
				cnt_d    = cnt_q - STEP_W'(1);
				if (cnt_q == '0) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

[hw/rtl/julia_escape_time_pixel.sv]
// julia escape-time pixel: top level
// Usage:
// - input channel (in_valid/in_stall) takes one pixel item: pixel_x, pixel_y.
// - output channel (out_valid/out_stall) returns one item per pixel:
//   red, green, blue and escape_count.
// - configuration is written through cfg_wr_en/cfg_index/cfg_wr_data; the user must
//   write it only while idle, as the block does not enforce this; indexes 0..7 select
//   c_real, c_imag, x_start, x_step, y_start, y_step, max_iterations and dark_threshold.
// - one item is worked at a time. the iteration loop runs one complex step per
//   cycle through one set of three multipliers until escape or max_iterations,
//   then a bit-serial divider and a bit-serial square root follow.
// - the next item can be accepted in the cycle after the result is loaded.
// - in_stall is high from accept until the result moves into the output register.
// - the output register holds the result while out_stall is high; the next item
//   is accepted and worked meanwhile, and waits at the end until the register frees.
// - reset clears control state and loads the default configuration; no item is
//   held after reset.
module julia_escape_time_pixel import jetp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PIX_W-1:0]     pixel_x,
	input  logic [PIX_W-1:0]     pixel_y,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [BYTE_W-1:0]    red,
	output logic [BYTE_W-1:0]    green,
	output logic [BYTE_W-1:0]    blue,
	output logic [ITER_W-1:0]    escape_count
);

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t st;

	jetp_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.cfg         (cfg)
	);

	jetp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	jetp_dp u_dp (
		.clk          (clk),
		.cfg          (cfg),
		.cmd          (cmd),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.st           (st),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.escape_count (escape_count)
	);

endmodule
